### rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants, codes, types and ring index helpers for the
// double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // operation codes
    localparam logic [1:0] FUNC_PUSH   = 2'd0;
    localparam logic [1:0] FUNC_POP    = 2'd1;
    localparam logic [1:0] FUNC_SEARCH = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [IDX_W-1:0]      addr;
        logic [DATA_WIDTH-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] item_value;
        logic                  found;
        logic [1:0]            status;
        logic [CNT_W-1:0]      occupancy;
    } t_res;

    // base + off modulo DEPTH, valid for off < DEPTH + 1
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
        logic [IDX_W-1:0] res;
        if (base == '0) begin
            res = IDX_W'(DEPTH - 1);
        end else begin
            res = base - IDX_W'(1);
        end
        return res;
    endfunction

endpackage

### rtl/deq_if.sv
// ----------------------------------------------------------------------------
// deq_req_if / deq_rsp_if
// Valid/ready channels for queue operations and their results.
// ----------------------------------------------------------------------------
interface deq_req_if;
    import deq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            func;
    logic                  at_head;
    logic [DATA_WIDTH-1:0] value;

    modport source (output valid, output func, output at_head, output value,
                    input ready);
    modport sink   (input valid, input func, input at_head, input value,
                    output ready);
endinterface

interface deq_rsp_if;
    import deq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] item_value;
    logic                  found;
    logic [1:0]            status;
    logic [CNT_W-1:0]      occupancy;

    modport source (output valid, output item_value, output found, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input item_value, input found, input status,
                    input occupancy, output ready);
endinterface

### rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Single-port synchronous RAM with a registered read. Read data holds
// until the next read.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Operation sequencer: keeps head index and count, drives the ring store,
// walks the store for a search and builds one result per operation.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    deq_req_if.sink                       i_req,
    output deq_pkg::t_mem_req             o_mem,
    input  logic [deq_pkg::DATA_WIDTH-1:0] i_rdata,
    output deq_pkg::t_res                 o_res,
    output logic                          o_res_valid,
    input  logic                          i_res_ready
);
    import deq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SRCH = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [IDX_W-1:0]      r_head, n_head;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_pos, n_pos;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    logic                  r_pop, n_pop;
    logic                  r_found, n_found;
    logic [1:0]            r_status, n_status;

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_pos    = r_pos;
        n_value  = r_value;
        n_pop    = r_pop;
        n_found  = r_found;
        n_status = r_status;
        o_mem       = '0;
        o_mem.wdata = i_req.value;
        o_res_valid = 1'b0;
        i_req.ready = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_pop    = 1'b0;
                    n_found  = 1'b0;
                    n_status = STAT_OK;
                    n_value  = i_req.value;
                    n_state  = S_DONE;
                    unique case (i_req.func)
                        FUNC_PUSH: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = STAT_FULL;
                            end else begin
                                o_mem.we = 1'b1;
                                n_count  = r_count + CNT_W'(1);
                                if (i_req.at_head) begin
                                    o_mem.addr = ring_dec(r_head);
                                    n_head     = ring_dec(r_head);
                                end else begin
                                    o_mem.addr = ring_add(r_head, r_count);
                                end
                            end
                        end
                        FUNC_POP: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                o_mem.re = 1'b1;
                                n_pop    = 1'b1;
                                n_count  = r_count - CNT_W'(1);
                                if (i_req.at_head) begin
                                    o_mem.addr = r_head;
                                    n_head     = ring_add(r_head, CNT_W'(1));
                                end else begin
                                    o_mem.addr = ring_add(r_head, r_count - CNT_W'(1));
                                end
                            end
                        end
                        FUNC_SEARCH: begin
                            if (r_count != '0) begin
                                o_mem.re   = 1'b1;
                                o_mem.addr = r_head;
                                n_pos      = CNT_W'(1);
                                n_state    = S_SRCH;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_head  = '0;
                            n_count = '0;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                // read data belongs to offset r_pos - 1
                if (i_rdata == r_value) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else if (r_pos == r_count) begin
                    n_state = S_DONE;
                end else begin
                    o_mem.re   = 1'b1;
                    o_mem.addr = ring_add(r_head, r_pos);
                    n_pos      = r_pos + CNT_W'(1);
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // no read is issued in the done state, so popped data is still on the port
    assign o_res.item_value = r_pop ? i_rdata : '0;
    assign o_res.found      = r_found;
    assign o_res.status     = r_status;
    assign o_res.occupancy  = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_pop   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_pop   <= n_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_value  <= n_value;
        r_found  <= n_found;
        r_status <= n_status;
    end

endmodule

### rtl/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of 16 words kept in a ring store RAM.
//
// Channels: i_req carries one operation per transfer (func, at_head, value);
// o_rsp returns exactly one result per operation (item_value, found, status,
// occupancy), in order.
// Sequencing: push, pop and clear pass the sequencer's idle and done states;
// a push that fits writes the RAM once, a pop from a non-empty queue reads it
// once, clear leaves it alone. A search reads one held entry per cycle from
// the RAM, stopping at the first match. The result loads the output register
// as the sequencer leaves done; i_req is ready again while it waits on o_rsp.
// Writes and reads of the store never fall in the same cycle for one entry,
// so no forwarding is needed.
// Reset: the queue becomes empty with head index zero; store contents are
// left as they are. While o_rsp is stalled with a result held, the
// sequencer finishes at most one more operation and then holds i_req off.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deq_req_if.sink    i_req,
    deq_rsp_if.source  o_rsp
);
    import deq_pkg::*;

    t_mem_req              mem_req;
    logic [DATA_WIDTH-1:0] rdata;
    t_res                  res;
    logic                  res_valid;
    logic                  res_ready;

    logic                  r_out_valid;
    t_res                  r_out;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_mem       (mem_req),
        .i_rdata     (rdata),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready)
    );

    deq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_re    (mem_req.re),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .o_rdata (rdata)
    );

    // output register, refilled in the cycle it drains
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.item_value = r_out.item_value;
    assign o_rsp.found      = r_out.found;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.occupancy  = r_out.occupancy;

endmodule

### dv/double_ended_queue_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit_test
// Self-checking bench for the double-ended queue unit. A shadow ring with its
// own head and count predicts every result, and results are checked in order.
// Directed corner cases come first, then random traffic biased toward
// filling and draining the ring, with idle cycles on both channels in two of its three phases.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_test;
    import deq_pkg::*;

    localparam int POOL_N = 8;

    // shadow ring that predicts the result of each accepted operation
    class deq_scoreboard;
        logic [DATA_WIDTH-1:0] ring_words [DEPTH];
        int                    head_pos;
        int                    held_cnt;
        t_res                  expected_q [$];
        int unsigned           mismatches;

        function new();
            head_pos   = 0;
            held_cnt   = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void predict_op(input logic [1:0] func, input logic at_head,
                                 input logic [DATA_WIDTH-1:0] value);
            t_res r;
            r = '0;
            r.status = STAT_OK;
            case (func)
                FUNC_PUSH: begin
                    if (held_cnt >= DEPTH) begin
                        r.status = STAT_FULL;
                    end else if (at_head) begin
                        head_pos = (head_pos + DEPTH - 1) % DEPTH;
                        ring_words[head_pos] = value;
                        held_cnt++;
                    end else begin
                        ring_words[(head_pos + held_cnt) % DEPTH] = value;
                        held_cnt++;
                    end
                end
                FUNC_POP: begin
                    if (held_cnt == 0) begin
                        r.status = STAT_EMPTY;
                    end else if (at_head) begin
                        r.item_value = ring_words[head_pos];
                        head_pos = (head_pos + 1) % DEPTH;
                        held_cnt--;
                    end else begin
                        r.item_value = ring_words[(head_pos + held_cnt - 1) % DEPTH];
                        held_cnt--;
                    end
                end
                FUNC_SEARCH: begin
                    // only held words take part in the compare
                    for (int i = 0; i < held_cnt; i++) begin
                        if (ring_words[(head_pos + i) % DEPTH] == value) begin
                            r.found = 1'b1;
                        end
                    end
                end
                FUNC_CLEAR: begin
                    head_pos = 0;
                    held_cnt = 0;
                end
            endcase
            r.occupancy = CNT_W'(held_cnt);
            expected_q.push_back(r);
        endfunction

        function void check_result(input logic [DATA_WIDTH-1:0] item_value,
                                   input logic found, input logic [1:0] status,
                                   input logic [CNT_W-1:0] occupancy);
            t_res want;
            if (expected_q.size() == 0) begin
                $error("result transfer with no operation outstanding");
                mismatches++;
            end else begin
                want = expected_q.pop_front();
                if (item_value !== want.item_value) begin
                    $error("item_value: expected %h, got %h", want.item_value, item_value);
                    mismatches++;
                end
                if (found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, found);
                    mismatches++;
                end
                if (status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
                if (occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    deq_req_if op_ch ();
    deq_rsp_if res_ch ();

    deq_scoreboard         sb;
    int                    src_idle_pct;
    int                    sink_idle_pct;
    logic [DATA_WIDTH-1:0] word_pool [POOL_N];

    double_ended_queue_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (op_ch),
        .o_rsp   (res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // returns at the edge where the operation transfer happens
    task automatic issue_op(input logic [1:0] func, input logic at_head,
                            input logic [DATA_WIDTH-1:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            op_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        op_ch.valid   <= 1'b1;
        op_ch.func    <= func;
        op_ch.at_head <= at_head;
        op_ch.value   <= value;
        @(posedge i_clk);
        while (!op_ch.ready) begin
            @(posedge i_clk);
        end
        sb.predict_op(func, at_head, value);
    endtask

    // hold off new operations until every result is back
    task automatic wait_drained();
        op_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (sb.pending() != 0);
    endtask

    function automatic logic [DATA_WIDTH-1:0] rand_word();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5) begin
            return '0;
        end else if (sel < 10) begin
            return '1;
        end else if (sel < 55) begin
            return word_pool[$urandom_range(POOL_N - 1)];
        end
        return DATA_WIDTH'($urandom);
    endfunction

    // push share moves per block so the ring swings between empty and full
    task automatic run_random(input int n_ops);
        int         push_pct;
        int         pick;
        logic [1:0] func;
        push_pct = 50;
        for (int k = 0; k < n_ops; k++) begin
            if (k % 40 == 0) begin
                push_pct = $urandom_range(65, 30);
            end
            pick = $urandom_range(99);
            if (pick < push_pct) begin
                func = FUNC_PUSH;
            end else if (pick < 85) begin
                func = FUNC_POP;
            end else if (pick < 97) begin
                func = FUNC_SEARCH;
            end else begin
                func = FUNC_CLEAR;
            end
            issue_op(func, 1'($urandom), rand_word());
        end
    endtask

    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            sb.check_result(res_ch.item_value, res_ch.found, res_ch.status,
                            res_ch.occupancy);
        end
    end

    initial begin
        sb = new();
        foreach (word_pool[i]) begin
            word_pool[i] = $urandom;
        end
        src_idle_pct  = 37;
        sink_idle_pct = 62;
        i_rst_n       <= 1'b0;
        op_ch.valid   <= 1'b0;
        op_ch.func    <= FUNC_PUSH;
        op_ch.at_head <= 1'b0;
        op_ch.value   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pops and search on an empty queue
        issue_op(FUNC_POP, 1'b1, '0);
        issue_op(FUNC_POP, 1'b0, '1);
        issue_op(FUNC_SEARCH, 1'b0, '0);
        // head and tail push into an empty queue
        issue_op(FUNC_PUSH, 1'b1, '0);
        issue_op(FUNC_POP, 1'b0, '0);
        issue_op(FUNC_PUSH, 1'b0, '1);
        issue_op(FUNC_SEARCH, 1'b1, '1);
        issue_op(FUNC_POP, 1'b1, '0);
        // fill from both ends, head index wraps below zero
        for (int k = 0; k < DEPTH; k++) begin
            issue_op(FUNC_PUSH, 1'(k % 2), {16'hA5C3, 16'(k * 4369)});
        end
        issue_op(FUNC_PUSH, 1'b1, 32'h1234_5678);
        issue_op(FUNC_PUSH, 1'b0, 32'h8765_4321);
        issue_op(FUNC_SEARCH, 1'b0, 32'h5A5A_5A5A);
        issue_op(FUNC_CLEAR, 1'b1, '1);
        issue_op(FUNC_POP, 1'b1, '0);
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct  = (ph == 0) ? 37 : (ph == 1) ? 62 : 0;
            sink_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 37 : 0;
            run_random(267);
            wait_drained();
        end

        // longest search plus the output register
        repeat (DEPTH + 4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
rtl/deq_pkg.sv
rtl/deq_if.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue_unit.sv
dv/double_ended_queue_unit_test.sv
